>>> rtl/zefp_pkg.sv
// Package for the ZIP extra field parser: record ids, phase codes,
// result struct and the timestamp slot decode function.
// No dependencies.
`default_nettype none

package zefp_pkg;

  localparam logic [15:0] ID_TIMES = 16'h5455;
  localparam logic [15:0] ID_UNIX  = 16'h7875;
  localparam int unsigned ID_MAX_LEN = 8;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'b01,
    PH_PAYLOAD = 2'b10
  } phase_t;

  typedef struct packed {
    logic [31:0] mtime;
    logic        has_mtime;
    logic [31:0] atime;
    logic        has_atime;
    logic [31:0] ctime;
    logic        has_ctime;
    logic        has_unix_ids;
    logic [31:0] user_id;
    logic [31:0] group_id;
  } res_t;

  // Which time value sits in 4-byte slot 'slot' of a timestamp payload.
  // Returns {hit, index}.
  function automatic logic [2:0] time_slot(input logic [2:0] flags,
                                           input logic [13:0] slot);
    logic [1:0] seen;
    logic       hit;
    logic [1:0] idx;
    seen = 2'd0;
    hit  = 1'b0;
    idx  = 2'd0;
    for (int f = 0; f < 3; f++) begin
      if (flags[f] && !hit) begin
        if (slot == {12'h000, seen}) begin
          hit = 1'b1;
          idx = 2'(f);
        end
        seen = seen + 2'd1;
      end
    end
    return {hit, idx};
  endfunction

endpackage

`default_nettype wire

>>> rtl/zefp_if.sv
// Valid/ready channel interfaces for the ZIP extra field parser:
// byte input channel and result channel. No dependencies.
`default_nettype none

interface zefp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface zefp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] mtime;
  logic        has_mtime;
  logic [31:0] atime;
  logic        has_atime;
  logic [31:0] ctime;
  logic        has_ctime;
  logic        has_unix_ids;
  logic [31:0] user_id;
  logic [31:0] group_id;

  modport source (output valid, output mtime, output has_mtime, output atime,
                  output has_atime, output ctime, output has_ctime,
                  output has_unix_ids, output user_id, output group_id,
                  input ready);
  modport sink   (input valid, input mtime, input has_mtime, input atime,
                  input has_atime, input ctime, input has_ctime,
                  input has_unix_ids, input user_id, input group_id,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/zefp_parser.sv
// Record parser state and per-byte update logic. One byte per enabled cycle;
// res carries the kept values as they stand after this byte.
// Depends on zefp_pkg.
`default_nettype none

module zefp_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  output zefp_pkg::res_t     res
);
  import zefp_pkg::*;

  phase_t           phase, phase_next;
  logic [15:0]      rec_id, rec_id_next;
  logic [15:0]      rec_size, rec_size_next;
  logic [15:0]      offset, offset_next;
  logic [7:0]       flags, flags_next;
  logic [31:0]      acc, acc_next;
  logic [2:0][31:0] pend_times, pend_times_next;
  logic [2:0]       pend_valid, pend_valid_next;
  logic [1:0][7:0]  id_len, id_len_next;
  logic [1:0][31:0] pend_ids, pend_ids_next;
  logic [2:0][31:0] kept_times, kept_times_next;
  logic [2:0]       kept_valid, kept_valid_next;
  logic [1:0][31:0] kept_ids, kept_ids_next;
  logic             kept_ids_valid, kept_ids_valid_next;

  logic        commit;
  logic [15:0] om1, om2, uj;
  logic [2:0]  tsel;
  logic [16:0] gid_at, gid_end, size_ext;
  logic [31:0] b_ext;

  assign om1   = offset - 16'd1;
  assign om2   = offset - 16'd2;
  assign uj    = om2 - 16'd1 - {8'h00, id_len[0]};
  assign tsel  = time_slot(flags[2:0], om1[15:2]);
  assign b_ext = {24'h000000, data_byte};

  always_comb begin
    phase_next          = phase;
    rec_id_next         = rec_id;
    rec_size_next       = rec_size;
    offset_next         = offset;
    flags_next          = flags;
    acc_next            = acc;
    pend_times_next     = pend_times;
    pend_valid_next     = pend_valid;
    id_len_next         = id_len;
    pend_ids_next       = pend_ids;
    kept_times_next     = kept_times;
    kept_valid_next     = kept_valid;
    kept_ids_next       = kept_ids;
    kept_ids_valid_next = kept_ids_valid;
    commit              = 1'b0;
    gid_at              = 17'd0;
    gid_end             = 17'd0;
    size_ext            = {1'b0, rec_size};

    if (en) begin
      if (phase != PH_PAYLOAD) begin
        case (offset[1:0])
          2'd0:    rec_id_next = {8'h00, data_byte};
          2'd1:    rec_id_next = {data_byte, rec_id[7:0]};
          2'd2:    rec_size_next = {8'h00, data_byte};
          default: rec_size_next = {data_byte, rec_size[7:0]};
        endcase
        offset_next = offset + 16'd1;
        if (offset[1:0] == 2'd3) begin
          // header done: fresh pending state; empty record has no effect
          offset_next     = 16'd0;
          flags_next      = 8'h00;
          acc_next        = 32'd0;
          pend_times_next = '0;
          pend_valid_next = 3'b000;
          id_len_next     = '0;
          pend_ids_next   = '0;
          phase_next      = (rec_size_next == 16'd0) ? PH_HEADER : PH_PAYLOAD;
        end
      end else begin
        if (rec_id == ID_TIMES) begin
          if (offset == 16'd0) begin
            flags_next = data_byte;
          end else if (tsel[2]) begin
            if (om1[1:0] == 2'd0) begin
              acc_next = b_ext;
            end else begin
              acc_next = acc | (b_ext << {om1[1:0], 3'b000});
            end
            if (om1[1:0] == 2'd3) begin
              pend_times_next[tsel[1:0]] = acc_next;
              if (acc_next != 32'd0) begin
                pend_valid_next[tsel[1:0]] = 1'b1;
              end
            end
          end
        end else if (rec_id == ID_UNIX) begin
          if (offset == 16'd1) begin
            id_len_next[0] = data_byte;
          end else if (offset >= 16'd2) begin
            if (om2 < {8'h00, id_len[0]}) begin
              if (om2 < 16'd4) begin
                pend_ids_next[0] = pend_ids[0] | (b_ext << {om2[1:0], 3'b000});
              end
            end else if (om2 == {8'h00, id_len[0]}) begin
              id_len_next[1] = data_byte;
            end else if (uj < {8'h00, id_len[1]} && uj < 16'd4) begin
              pend_ids_next[1] = pend_ids[1] | (b_ext << {uj[1:0], 3'b000});
            end
          end
        end
        offset_next = offset + 16'd1;
        commit      = (offset_next == rec_size);
      end
    end

    if (commit) begin
      phase_next  = PH_HEADER;
      offset_next = 16'd0;
      if (rec_id == ID_TIMES) begin
        for (int i = 0; i < 3; i++) begin
          if (pend_valid_next[i]) begin
            kept_times_next[i] = pend_times_next[i];
            kept_valid_next[i] = 1'b1;
          end
        end
      end else if (rec_id == ID_UNIX) begin
        gid_at  = 17'd2 + {9'h000, id_len_next[0]};
        gid_end = gid_at + 17'd1 + {9'h000, id_len_next[1]};
        if (rec_size >= 16'd3 && gid_at < size_ext && gid_end <= size_ext) begin
          for (int i = 0; i < 2; i++) begin
            kept_ids_next[i] = (id_len_next[i] != 8'd0 &&
                                id_len_next[i] <= 8'(ID_MAX_LEN)) ?
                               pend_ids_next[i] : 32'd0;
          end
          kept_ids_valid_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.mtime        = kept_times_next[0];
    res.has_mtime    = kept_valid_next[0];
    res.atime        = kept_times_next[1];
    res.has_atime    = kept_valid_next[1];
    res.ctime        = kept_times_next[2];
    res.has_ctime    = kept_valid_next[2];
    res.has_unix_ids = kept_ids_valid_next;
    res.user_id      = kept_ids_next[0];
    res.group_id     = kept_ids_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst || (en && last_byte)) begin
      // the final byte of a field returns everything to reset
      phase          <= PH_HEADER;
      rec_id         <= 16'd0;
      rec_size       <= 16'd0;
      offset         <= 16'd0;
      flags          <= 8'h00;
      acc            <= 32'd0;
      pend_times     <= '0;
      pend_valid     <= 3'b000;
      id_len         <= '0;
      pend_ids       <= '0;
      kept_times     <= '0;
      kept_valid     <= 3'b000;
      kept_ids       <= '0;
      kept_ids_valid <= 1'b0;
    end else begin
      phase          <= phase_next;
      rec_id         <= rec_id_next;
      rec_size       <= rec_size_next;
      offset         <= offset_next;
      flags          <= flags_next;
      acc            <= acc_next;
      pend_times     <= pend_times_next;
      pend_valid     <= pend_valid_next;
      id_len         <= id_len_next;
      pend_ids       <= pend_ids_next;
      kept_times     <= kept_times_next;
      kept_valid     <= kept_valid_next;
      kept_ids       <= kept_ids_next;
      kept_ids_valid <= kept_ids_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/zip_extra_field_parser_top.sv
// A last byte accepted into the input register has its result captured in the
// result register when it advances. Throughput: one byte per cycle; the parser
// update lies between the input register and the result register.
// A result waiting at the output stalls only a following last byte.
// Reset: synchronous, active-high rst empties both registers and clears the
// parser; ready is low while rst is high.
`default_nettype none

module zip_extra_field_parser_top (
  input wire logic  clk,
  input wire logic  rst,
  zefp_in_if.sink   field_bytes,
  zefp_out_if.source result
);
  import zefp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       advance;
  logic       out_valid;
  res_t       out_res;
  res_t       res;

  assign advance = s1_valid && (!s1_last || !out_valid || result.ready);
  assign field_bytes.ready = !rst && (!s1_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (field_bytes.ready) begin
      s1_valid <= field_bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (field_bytes.ready) begin
      s1_byte <= field_bytes.data_byte;
      s1_last <= field_bytes.last_byte;
    end
  end

  zefp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      out_res <= res;
    end
  end

  assign result.valid        = out_valid;
  assign result.mtime        = out_res.mtime;
  assign result.has_mtime    = out_res.has_mtime;
  assign result.atime        = out_res.atime;
  assign result.has_atime    = out_res.has_atime;
  assign result.ctime        = out_res.ctime;
  assign result.has_ctime    = out_res.has_ctime;
  assign result.has_unix_ids = out_res.has_unix_ids;
  assign result.user_id      = out_res.user_id;
  assign result.group_id     = out_res.group_id;

`ifndef SYNTH
  // a last byte blocked by an untaken result stays in the input register
  a_last_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && out_valid && !result.ready) |=> (s1_valid && s1_last))
    else $error("last byte lost while result stalled");

  // a new result only ever follows a processed last byte
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && s1_last))
    else $error("result raised without a last byte");

  // a stalled result keeps its value until taken
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
